FILE: design/cfr_pkg.sv
// ----------------------------------------------------------------------------
// cfr_pkg
// Shared types and constants of the CAN fragment reassembler.
// ----------------------------------------------------------------------------
`default_nettype none

package cfr_pkg;

   // payload store
   localparam int PAYLOAD_DEPTH = 256;
   localparam int ADDR_W        = $clog2(PAYLOAD_DEPTH);
   localparam int COUNT_W       = 9;
   localparam int CRC_W         = 16;

   localparam logic [COUNT_W-1:0] DEPTH_COUNT = COUNT_W'(PAYLOAD_DEPTH);

   // CRC-16/ARC, reflected
   localparam logic [CRC_W-1:0] CRC_POLY = 16'hA001;

   typedef enum logic [1:0] {
      PT_START  = 2'd0,
      PT_MIDDLE = 2'd1,
      PT_END    = 2'd2,
      PT_SINGLE = 2'd3
   } ptype_type;

   typedef enum logic [2:0] {
      ST_READ_REPLY = 3'd0,
      ST_IGNORED    = 3'd1,
      ST_SEQ_ERR    = 3'd2,
      ST_FRAG_OK    = 3'd3,
      ST_SINGLE_OK  = 3'd4,
      ST_MULTI_OK   = 3'd5,
      ST_CRC_FAIL   = 3'd6
   } status_type;

   typedef enum logic [2:0] {
      FS_IDLE,
      FS_READ,
      FS_OFFER,
      FS_CHECK,
      FS_RESP
   } fsm_type;

   // control from the sequencer to the CRC unit
   typedef struct packed {
      logic       clear;
      logic       update;
      logic [7:0] data;
   } crc_ctrl_type;

endpackage

`default_nettype wire

FILE: design/cfr_ram.sv
// ----------------------------------------------------------------------------
// cfr_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module cfr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [0:DEPTH-1];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

`default_nettype wire

FILE: design/cfr_crc_unit.sv
// ----------------------------------------------------------------------------
// cfr_crc_unit
// Running CRC-16/ARC register, one data byte folded in per cycle while update is set.
// ----------------------------------------------------------------------------
`default_nettype none

module cfr_crc_unit (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire cfr_pkg::crc_ctrl_type ctrl,
   output logic [cfr_pkg::CRC_W-1:0]  crc
);

   logic [cfr_pkg::CRC_W-1:0] crc_ff;
   logic [cfr_pkg::CRC_W-1:0] crc_in;
   logic [cfr_pkg::CRC_W-1:0] step;

   // eight shift/xor steps of the reflected polynomial
   always_comb begin
      step = crc_ff ^ {8'h00, ctrl.data};
      for (int k = 0; k < 8; k++) begin
         step = step[0] ? ((step >> 1) ^ cfr_pkg::CRC_POLY) : (step >> 1);
      end
      if (ctrl.clear) begin
         crc_in = '0;
      end else if (ctrl.update) begin
         crc_in = step;
      end else begin
         crc_in = crc_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         crc_ff <= '0;
      end else begin
         crc_ff <= crc_in;
      end
   end

   assign crc = crc_ff;

endmodule

`default_nettype wire

FILE: design/can_fragment_reassembler_crc16.sv
// ----------------------------------------------------------------------------
// can_fragment_reassembler_crc16
// Reassembles multi-frame packets from standard CAN frames, CRC-16/ARC check.
// ----------------------------------------------------------------------------
// Usage:
//  - req_* carries one request: a received frame (op 0) or a read of one
//    stored payload byte (op 1). rsp_* returns exactly one result per request.
//  - req_ready is high only while the sequencer is idle; one request is
//    worked on at a time.
//  - A frame walks its data bytes through the shared CRC unit (single frames
//    skip it) and the payload RAM write port, one byte per cycle; an end
//    frame then passes a CRC compare state. Extended frames and sequence
//    mismatches go from idle straight to the result, reads through a read
//    state (the RAM read is registered).
//  - The result stays on rsp_* until rsp_ready; no new request is taken
//    until it has gone, so a stalled receiver simply holds the block.
//  - Header fields on rsp_* show the stored state after the request.
//  - Reset clears the header, count and CRC. The payload RAM is not
//    cleared: only entries below the stored count are ever returned, and
//    those were written since the last start or single frame, or reset.
// ----------------------------------------------------------------------------
`default_nettype none

module can_fragment_reassembler_crc16 (
   input  wire logic        clock,
   input  wire logic        reset,
   // request channel
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic        req_op,
   input  wire logic        req_extended_frame,
   input  wire logic [10:0] req_msg_id,
   input  wire logic [7:0]  req_byte0,
   input  wire logic [7:0]  req_byte1,
   input  wire logic [7:0]  req_byte2,
   input  wire logic [7:0]  req_byte3,
   input  wire logic [7:0]  req_byte4,
   input  wire logic [7:0]  req_byte5,
   input  wire logic [7:0]  req_byte6,
   input  wire logic [7:0]  req_byte7,
   input  wire logic [7:0]  req_read_index,
   // result channel
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [2:0]       rsp_status,
   output logic [2:0]       rsp_priority_res,
   output logic [3:0]       rsp_destination,
   output logic [3:0]       rsp_sequence_res,
   output logic [7:0]       rsp_packet_size,
   output logic [8:0]       rsp_bytes_stored,
   output logic [15:0]      rsp_running_crc,
   output logic [7:0]       rsp_read_data
);

   // sequencer state
   cfr_pkg::fsm_type     state_ff, state_in;
   logic [2:0]           pos_ff, pos_in;       // byte position in the frame
   logic [2:0]           last_ff, last_in;     // last byte position to offer
   cfr_pkg::ptype_type   kind_ff, kind_in;
   cfr_pkg::status_type  status_ff, status_in;
   logic                 hit_ff, hit_in;       // read index below count
   logic [7:0]           rdata_ff, rdata_in;

   // packet state
   logic [2:0]                    prio_ff, prio_in;
   logic [3:0]                    dest_ff, dest_in;
   logic [3:0]                    seq_ff, seq_in;
   logic [7:0]                    size_ff, size_in;
   logic [cfr_pkg::COUNT_W-1:0]   count_ff, count_in;

   // captured frame bytes (payload, no reset)
   logic [7:0] data_ff [0:7];
   logic       capture;

   // RAM and CRC unit
   logic                        wr_en;
   logic [cfr_pkg::ADDR_W-1:0]  wr_addr;
   logic [7:0]                  wr_data;
   logic [7:0]                  ram_q;
   cfr_pkg::crc_ctrl_type       crc_ctrl;
   logic [cfr_pkg::CRC_W-1:0]   crc_val;

   logic       room;
   logic [7:0] cur_byte;
   logic [2:0] pos_m1;
   cfr_pkg::ptype_type req_kind;

   assign req_kind = cfr_pkg::ptype_type'(req_byte0[7:6]);
   assign cur_byte = data_ff[pos_ff];
   assign pos_m1   = pos_ff - 3'd1;
   // storing limit: count at most the declared size and below the depth
   assign room     = (count_ff <= {1'b0, size_ff}) && (count_ff < cfr_pkg::DEPTH_COUNT);

   cfr_ram #(
      .WIDTH (8),
      .DEPTH (cfr_pkg::PAYLOAD_DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (req_read_index[cfr_pkg::ADDR_W-1:0]),
      .rd_data (ram_q)
   );

   cfr_crc_unit u_crc (
      .clock (clock),
      .reset (reset),
      .ctrl  (crc_ctrl),
      .crc   (crc_val)
   );

   always_comb begin
      state_in  = state_ff;
      pos_in    = pos_ff;
      last_in   = last_ff;
      kind_in   = kind_ff;
      status_in = status_ff;
      hit_in    = hit_ff;
      rdata_in  = rdata_ff;
      prio_in   = prio_ff;
      dest_in   = dest_ff;
      seq_in    = seq_ff;
      size_in   = size_ff;
      count_in  = count_ff;
      capture   = 1'b0;
      wr_en     = 1'b0;
      wr_addr   = count_ff[cfr_pkg::ADDR_W-1:0];
      wr_data   = cur_byte;
      crc_ctrl  = '{clear: 1'b0, update: 1'b0, data: cur_byte};

      unique case (state_ff)
         cfr_pkg::FS_IDLE: begin
            if (req_valid) begin
               capture  = 1'b1;
               kind_in  = req_kind;
               rdata_in = 8'h00;
               if (req_op) begin
                  hit_in   = ({1'b0, req_read_index} < count_ff);
                  state_in = cfr_pkg::FS_READ;
               end else if (req_extended_frame) begin
                  status_in = cfr_pkg::ST_IGNORED;
                  state_in  = cfr_pkg::FS_RESP;
               end else begin
                  unique case (req_kind) inside
                     cfr_pkg::PT_SINGLE: begin
                        prio_in  = req_msg_id[10:8];
                        dest_in  = req_msg_id[7:4];
                        seq_in   = req_msg_id[3:0];
                        size_in  = {2'b00, req_byte0[5:0]};
                        count_in = '0;
                        crc_ctrl.clear = 1'b1;
                        pos_in   = 3'd1;
                        last_in  = 3'd7;
                        state_in = cfr_pkg::FS_OFFER;
                     end
                     cfr_pkg::PT_START: begin
                        prio_in  = req_msg_id[10:8];
                        dest_in  = req_msg_id[7:4];
                        seq_in   = req_msg_id[3:0];
                        size_in  = req_byte1;
                        count_in = '0;
                        crc_ctrl.clear = 1'b1;
                        pos_in   = 3'd2;
                        last_in  = 3'd7;
                        state_in = cfr_pkg::FS_OFFER;
                     end
                     cfr_pkg::PT_MIDDLE, cfr_pkg::PT_END: begin
                        if (req_msg_id[3:0] != seq_ff) begin
                           status_in = cfr_pkg::ST_SEQ_ERR;
                           state_in  = cfr_pkg::FS_RESP;
                        end else begin
                           pos_in   = 3'd1;
                           last_in  = (req_kind == cfr_pkg::PT_END) ? 3'd5 : 3'd7;
                           state_in = cfr_pkg::FS_OFFER;
                        end
                     end
                     default: begin
                        state_in = cfr_pkg::FS_IDLE;
                     end
                  endcase
               end
            end
         end

         cfr_pkg::FS_READ: begin
            // registered RAM data is valid now
            status_in = cfr_pkg::ST_READ_REPLY;
            rdata_in  = hit_ff ? ram_q : 8'h00;
            state_in  = cfr_pkg::FS_RESP;
         end

         cfr_pkg::FS_OFFER: begin
            if (kind_ff == cfr_pkg::PT_SINGLE) begin
               // single frame: stored at position-1, no CRC
               wr_en    = 1'b1;
               wr_addr  = {{(cfr_pkg::ADDR_W-3){1'b0}}, pos_m1};
               count_in = count_ff + 1'b1;
            end else if (room) begin
               wr_en           = 1'b1;
               crc_ctrl.update = 1'b1;
               count_in        = count_ff + 1'b1;
            end
            if (pos_ff == last_ff) begin
               unique case (kind_ff)
                  cfr_pkg::PT_SINGLE: begin
                     status_in = cfr_pkg::ST_SINGLE_OK;
                     state_in  = cfr_pkg::FS_RESP;
                  end
                  cfr_pkg::PT_END: begin
                     state_in = cfr_pkg::FS_CHECK;
                  end
                  default: begin
                     status_in = cfr_pkg::ST_FRAG_OK;
                     state_in  = cfr_pkg::FS_RESP;
                  end
               endcase
            end else begin
               pos_in = pos_ff + 3'd1;
            end
         end

         cfr_pkg::FS_CHECK: begin
            status_in = ({data_ff[6], data_ff[7]} == crc_val) ? cfr_pkg::ST_MULTI_OK
                                                              : cfr_pkg::ST_CRC_FAIL;
            state_in  = cfr_pkg::FS_RESP;
         end

         cfr_pkg::FS_RESP: begin
            if (rsp_ready) begin
               state_in = cfr_pkg::FS_IDLE;
            end
         end

         default: begin
            state_in = cfr_pkg::FS_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= cfr_pkg::FS_IDLE;
         prio_ff  <= '0;
         dest_ff  <= '0;
         seq_ff   <= '0;
         size_ff  <= '0;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         prio_ff  <= prio_in;
         dest_ff  <= dest_in;
         seq_ff   <= seq_in;
         size_ff  <= size_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      pos_ff    <= pos_in;
      last_ff   <= last_in;
      kind_ff   <= kind_in;
      status_ff <= status_in;
      hit_ff    <= hit_in;
      rdata_ff  <= rdata_in;
      if (capture) begin
         data_ff[0] <= req_byte0;
         data_ff[1] <= req_byte1;
         data_ff[2] <= req_byte2;
         data_ff[3] <= req_byte3;
         data_ff[4] <= req_byte4;
         data_ff[5] <= req_byte5;
         data_ff[6] <= req_byte6;
         data_ff[7] <= req_byte7;
      end
   end

   assign req_ready = (state_ff == cfr_pkg::FS_IDLE);
   assign rsp_valid = (state_ff == cfr_pkg::FS_RESP);

   // header fields come straight from the state, which holds while a result waits
   assign rsp_status       = status_ff;
   assign rsp_priority_res = prio_ff;
   assign rsp_destination  = dest_ff;
   assign rsp_sequence_res = seq_ff;
   assign rsp_packet_size  = size_ff;
   assign rsp_bytes_stored = count_ff;
   assign rsp_running_crc  = crc_val;
   assign rsp_read_data    = rdata_ff;

endmodule

`default_nettype wire
